FILE: rtl/cau_pkg.sv
package cau_pkg;

   // operation codes
   localparam logic [3:0] KIND_ADD  = 4'd0;
   localparam logic [3:0] KIND_SUB  = 4'd1;
   localparam logic [3:0] KIND_MULS = 4'd2;
   localparam logic [3:0] KIND_DIVS = 4'd3;
   localparam logic [3:0] KIND_MUL  = 4'd4;
   localparam logic [3:0] KIND_DIV  = 4'd5;
   localparam logic [3:0] KIND_EQ   = 4'd6;
   localparam logic [3:0] KIND_NE   = 4'd7;
   localparam logic [3:0] KIND_LT   = 4'd8;
   localparam logic [3:0] KIND_GT   = 4'd9;
   localparam logic [3:0] KIND_LE   = 4'd10;
   localparam logic [3:0] KIND_GE   = 4'd11;
   localparam logic [3:0] KIND_MAG  = 4'd12;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIVZ = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   // quotient bits kept by the divider chain, root bits of the sqrt chain
   localparam int QW = 33;
   localparam int SQ = 32;

   typedef struct packed {
      logic        ovf;
      logic [31:0] val;
   } satv_type;

   // per-transaction side data traveling next to the cell chains
   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] re;
      logic [31:0] im;
      logic        flag;
      logic [1:0]  status;
      logic        neg_re;
      logic        neg_im;
      logic        dz;
      logic        ovf_re;
      logic        ovf_im;
   } side_type;

   localparam logic signed [65:0] SMAX = 66'sd2147483647;
   localparam logic signed [65:0] SMIN = -66'sd2147483648;

   // signed wide value to saturated 32 bits
   function automatic satv_type sat_s66(input logic signed [65:0] v);
      satv_type r;
      if (v > SMAX) begin
         r.ovf = 1'b1;
         r.val = 32'h7FFF_FFFF;
      end else if (v < SMIN) begin
         r.ovf = 1'b1;
         r.val = 32'h8000_0000;
      end else begin
         r.ovf = 1'b0;
         r.val = v[31:0];
      end
      return r;
   endfunction

   // sign and quotient magnitude to saturated 32 bits
   function automatic satv_type sat_q(input logic neg, input logic [QW-1:0] q,
                                      input logic big);
      satv_type r;
      if (!neg) begin
         r.ovf = big || (q > 33'h0_7FFF_FFFF);
         r.val = r.ovf ? 32'h7FFF_FFFF : q[31:0];
      end else begin
         r.ovf = big || (q > 33'h0_8000_0000);
         r.val = r.ovf ? 32'h8000_0000 : (~q[31:0]) + 32'd1;
      end
      return r;
   endfunction

endpackage

FILE: rtl/cau_div_cell.sv
module cau_div_cell #(
   parameter int RW    = 80,
   parameter int SHIFT = 0
) (
   input  logic                   clock,
   input  logic [RW-1:0]          rem_from,
   input  logic [63:0]            den_from,
   input  logic [cau_pkg::QW-1:0] quo_from,
   output logic [RW-1:0]          rem_to,
   output logic [63:0]            den_to,
   output logic [cau_pkg::QW-1:0] quo_to
);
   import cau_pkg::*;

   logic [RW-1:0] hi;
   logic [RW-1:0] rem_sub;
   logic          ge;
   logic [RW-1:0] rem_in;
   logic [RW-1:0] rem_ff;
   logic [63:0]   den_ff;
   logic [QW-1:0] quo_ff;

   // compare against the divisor at this bit weight, subtract when it fits
   always_comb begin
      hi      = rem_from >> SHIFT;
      ge      = hi >= RW'(den_from);
      rem_sub = rem_from - (RW'(den_from) << SHIFT);
      rem_in  = ge ? rem_sub : rem_from;
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_from;
      quo_ff <= {quo_from[QW-2:0], ge};
   end

   assign rem_to = rem_ff;
   assign den_to = den_ff;
   assign quo_to = quo_ff;
endmodule

FILE: rtl/cau_sqrt_cell.sv
module cau_sqrt_cell #(
   parameter int K = 0
) (
   input  logic        clock,
   input  logic [63:0] val_from,
   input  logic [63:0] res_from,
   output logic [63:0] val_to,
   output logic [63:0] res_to
);
   import cau_pkg::*;

   localparam logic [63:0] BIT = 64'd1 << (2 * K);

   logic [63:0] trial;
   logic        ge;
   logic [63:0] val_in;
   logic [63:0] res_in;
   logic [63:0] val_ff;
   logic [63:0] res_ff;

   // one root digit per cell
   always_comb begin
      trial  = res_from + BIT;
      ge     = val_from >= trial;
      val_in = ge ? val_from - trial : val_from;
      res_in = ge ? (res_from >> 1) + BIT : res_from >> 1;
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      res_ff <= res_in;
   end

   assign val_to = val_ff;
   assign res_to = res_ff;
endmodule

FILE: rtl/complex_arith_unit.sv
// a result strobes on rsp_valid once its transaction has passed every stage and the output register
// throughput: one transaction per cycle, busy is never raised
// speed set by the 33-cell restoring divider chain, one quotient bit per cell
// reset: synchronous, active high; clears only the valid pipeline and rsp_valid
// the receiver cannot stall: every result is shown for exactly one cycle
module complex_arith_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_kind,
   input  logic signed [31:0] req_a_re,
   input  logic signed [31:0] req_a_im,
   input  logic signed [31:0] req_b_re,
   input  logic signed [31:0] req_b_im,
   input  logic signed [31:0] req_scale,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_res_re,
   output logic signed [31:0] rsp_res_im,
   output logic               rsp_flag,
   output logic [1:0]         rsp_status
);
   import cau_pkg::*;

   // dividend width: 64-bit numerator with the fraction shift appended
   localparam int RW  = 64 + FRAC_BITS;
   // stages before the output register: capture, multiply, sum, then the divider cells
   localparam int NST = 3 + QW;

   logic accept;
   assign accept = start && !busy;
   assign busy   = 1'b0;

   // valid pipeline, one bit per stage
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   assign vld_in = {vld_ff[NST-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- stage 1: operand capture ----------------
   logic [3:0]         k1_ff;
   logic signed [31:0] ar1_ff, ai1_ff, br1_ff, bi1_ff, sc1_ff;

   always_ff @(posedge clock) begin
      k1_ff  <= req_kind;
      ar1_ff <= req_a_re;
      ai1_ff <= req_a_im;
      br1_ff <= req_b_re;
      bi1_ff <= req_b_im;
      sc1_ff <= req_scale;
   end

   // ---------------- stage 2: products and the simple operations ----------------
   logic signed [31:0] mx [6];
   logic signed [31:0] my [6];
   logic signed [63:0] prod_in [6];
   logic signed [63:0] prod_ff [6];
   logic signed [32:0] add_re, add_im;
   satv_type           sv_re, sv_im;
   side_type           e2_in, e2_ff;
   logic [31:0]        abs_re_in, abs_im_in, abs_sc_in;
   logic [31:0]        abs_re_ff, abs_im_ff, abs_sc_ff;

   always_comb begin
      // of the four shared multipliers, the first two change operands with the kind
      mx[0] = ar1_ff; my[0] = ar1_ff;
      mx[1] = ai1_ff; my[1] = ai1_ff;
      mx[2] = ar1_ff; my[2] = bi1_ff;
      mx[3] = ai1_ff; my[3] = br1_ff;
      if (k1_ff == KIND_MULS) begin
         my[0] = sc1_ff;
         my[1] = sc1_ff;
      end else if (k1_ff == KIND_MUL || k1_ff == KIND_DIV) begin
         my[0] = br1_ff;
         my[1] = bi1_ff;
      end
      // |b|^2 terms always
      mx[4] = br1_ff; my[4] = br1_ff;
      mx[5] = bi1_ff; my[5] = bi1_ff;
      for (int i = 0; i < 6; i++) begin
         prod_in[i] = 64'(mx[i]) * 64'(my[i]);
      end
   end

   always_comb begin
      e2_in        = '0;
      e2_in.kind   = k1_ff;
      e2_in.status = ST_OK;
      add_re       = '0;
      add_im       = '0;
      if (k1_ff == KIND_SUB) begin
         add_re = 33'(ar1_ff) - 33'(br1_ff);
         add_im = 33'(ai1_ff) - 33'(bi1_ff);
      end else begin
         add_re = 33'(ar1_ff) + 33'(br1_ff);
         add_im = 33'(ai1_ff) + 33'(bi1_ff);
      end
      sv_re = sat_s66(66'(add_re));
      sv_im = sat_s66(66'(add_im));
      abs_re_in = ar1_ff[31] ? 32'(-ar1_ff) : ar1_ff;
      abs_im_in = ai1_ff[31] ? 32'(-ai1_ff) : ai1_ff;
      abs_sc_in = sc1_ff[31] ? 32'(-sc1_ff) : sc1_ff;
      case (k1_ff) inside
         KIND_ADD, KIND_SUB: begin
            e2_in.re     = sv_re.val;
            e2_in.im     = sv_im.val;
            e2_in.status = (sv_re.ovf || sv_im.ovf) ? ST_SAT : ST_OK;
         end
         KIND_EQ: e2_in.flag = (ar1_ff == br1_ff) && (ai1_ff == bi1_ff);
         KIND_NE: e2_in.flag = (ar1_ff != br1_ff) || (ai1_ff != bi1_ff);
         KIND_DIVS: begin
            // quotient sign is the xor of the operand signs
            e2_in.neg_re = ar1_ff[31] ^ sc1_ff[31];
            e2_in.neg_im = ai1_ff[31] ^ sc1_ff[31];
            if (sc1_ff == 32'sd0) begin
               e2_in.dz     = 1'b1;
               e2_in.status = ST_DIVZ;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 6; i++) begin
         prod_ff[i] <= prod_in[i];
      end
      e2_ff     <= e2_in;
      abs_re_ff <= abs_re_in;
      abs_im_ff <= abs_im_in;
      abs_sc_ff <= abs_sc_in;
   end

   // ---------------- stage 3: product sums, compares, divider setup ----------------
   logic signed [65:0] s_pp, s_pm, s_cross, s_dim, s_b2;
   logic [63:0]        sqa, sqb;
   satv_type           m_re, m_im;
   side_type           side0_in;
   side_type           side_in [QW+1];
   side_type           side_ff [QW+1];
   logic [63:0]        num_re_in, num_im_in, den_in, sqv_in;
   logic [63:0]        num_re_ff, num_im_ff, den_ff, sqv_ff;

   always_comb begin
      s_pp    = 66'(prod_ff[0]) + 66'(prod_ff[1]);
      s_pm    = 66'(prod_ff[0]) - 66'(prod_ff[1]);
      s_cross = 66'(prod_ff[2]) + 66'(prod_ff[3]);
      s_dim   = 66'(prod_ff[3]) - 66'(prod_ff[2]);
      s_b2    = 66'(prod_ff[4]) + 66'(prod_ff[5]);
      sqa     = s_pp[63:0];
      sqb     = s_b2[63:0];
      m_re    = sat_s66(s_pp >>> FRAC_BITS);
      m_im    = sat_s66(s_cross >>> FRAC_BITS);
      side0_in  = e2_ff;
      num_re_in = '0;
      num_im_in = '0;
      den_in    = '0;
      sqv_in    = sqa;
      case (e2_ff.kind)
         KIND_MULS: begin
            // floor of the scaled product, saturated per part
            m_re = sat_s66(66'(prod_ff[0]) >>> FRAC_BITS);
            m_im = sat_s66(66'(prod_ff[1]) >>> FRAC_BITS);
            side0_in.re     = m_re.val;
            side0_in.im     = m_im.val;
            side0_in.status = (m_re.ovf || m_im.ovf) ? ST_SAT : ST_OK;
         end
         KIND_MUL: begin
            m_re = sat_s66(s_pm >>> FRAC_BITS);
            side0_in.re     = m_re.val;
            side0_in.im     = m_im.val;
            side0_in.status = (m_re.ovf || m_im.ovf) ? ST_SAT : ST_OK;
         end
         KIND_DIVS: begin
            num_re_in = 64'(abs_re_ff);
            num_im_in = 64'(abs_im_ff);
            den_in    = 64'(abs_sc_ff);
         end
         KIND_DIV: begin
            // conj product numerator as sign and magnitude, |b|^2 divisor
            side0_in.neg_re = s_pp[65];
            side0_in.neg_im = s_dim[65];
            num_re_in = s_pp[65] ? 64'(-s_pp) : s_pp[63:0];
            num_im_in = s_dim[65] ? 64'(-s_dim) : s_dim[63:0];
            den_in    = sqb;
            if (sqb == 64'd0) begin
               side0_in.dz     = 1'b1;
               side0_in.status = ST_DIVZ;
            end
         end
         KIND_LT: side0_in.flag = sqa <  sqb;
         KIND_GT: side0_in.flag = sqa >  sqb;
         KIND_LE: side0_in.flag = sqa <= sqb;
         KIND_GE: side0_in.flag = sqa >= sqb;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      num_re_ff  <= num_re_in;
      num_im_ff  <= num_im_in;
      den_ff     <= den_in;
      sqv_ff     <= sqv_in;
   end

   // ---------------- divider chains, one quotient bit per cell ----------------
   logic [RW-1:0] rem_re [QW+1];
   logic [RW-1:0] rem_im [QW+1];
   logic [63:0]   dvr_re [QW+1];
   logic [63:0]   dvr_im [QW+1];
   logic [QW-1:0] quo_re [QW+1];
   logic [QW-1:0] quo_im [QW+1];

   assign rem_re[0] = RW'(num_re_ff) << FRAC_BITS;
   assign rem_im[0] = RW'(num_im_ff) << FRAC_BITS;
   assign dvr_re[0] = den_ff;
   assign dvr_im[0] = den_ff;
   assign quo_re[0] = '0;
   assign quo_im[0] = '0;

   for (genvar d = 0; d < QW; d++) begin : g_div
      cau_div_cell #(.RW(RW), .SHIFT(QW - 1 - d)) u_re (
         .clock    (clock),
         .rem_from (rem_re[d]),
         .den_from (dvr_re[d]),
         .quo_from (quo_re[d]),
         .rem_to   (rem_re[d+1]),
         .den_to   (dvr_re[d+1]),
         .quo_to   (quo_re[d+1])
      );
      cau_div_cell #(.RW(RW), .SHIFT(QW - 1 - d)) u_im (
         .clock    (clock),
         .rem_from (rem_im[d]),
         .den_from (dvr_im[d]),
         .quo_from (quo_im[d]),
         .rem_to   (rem_im[d+1]),
         .den_to   (dvr_im[d+1]),
         .quo_to   (quo_im[d+1])
      );
   end

   // ---------------- square root chain, one root bit per cell ----------------
   logic [63:0] sq_val [SQ+1];
   logic [63:0] sq_res [SQ+1];

   assign sq_val[0] = sqv_ff;
   assign sq_res[0] = '0;

   for (genvar j = 0; j < SQ; j++) begin : g_sqrt
      cau_sqrt_cell #(.K(SQ - 1 - j)) u_cell (
         .clock    (clock),
         .val_from (sq_val[j]),
         .res_from (sq_res[j]),
         .val_to   (sq_val[j+1]),
         .res_to   (sq_res[j+1])
      );
   end

   // ---------------- side data beside the chains ----------------
   satv_type sq_sat;

   always_comb begin
      sq_sat     = sat_q(1'b0, sq_res[SQ][QW-1:0], 1'b0);
      side_in[0] = side0_in;
      for (int j = 1; j <= QW; j++) begin
         side_in[j] = side_ff[j-1];
         if (j == 1) begin
            // a quotient of 2^33 or more saturates whatever its low bits
            side_in[j].ovf_re = (rem_re[0] >> QW) >= RW'(den_ff);
            side_in[j].ovf_im = (rem_im[0] >> QW) >= RW'(den_ff);
         end
         if (j == SQ + 1 && side_ff[j-1].kind == KIND_MAG) begin
            // root leaves its last cell here
            side_in[j].re     = sq_sat.val;
            side_in[j].status = sq_sat.ovf ? ST_SAT : ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= QW; j++) begin
         side_ff[j] <= side_in[j];
      end
   end

   // ---------------- output register ----------------
   side_type    out_in;
   satv_type    q_re, q_im;
   logic        rsp_valid_ff;
   logic [31:0] rsp_re_ff, rsp_im_ff;
   logic        rsp_flag_ff;
   logic [1:0]  rsp_status_ff;

   always_comb begin
      out_in = side_ff[QW];
      q_re   = sat_q(out_in.neg_re, quo_re[QW], out_in.ovf_re);
      q_im   = sat_q(out_in.neg_im, quo_im[QW], out_in.ovf_im);
      if ((out_in.kind == KIND_DIV || out_in.kind == KIND_DIVS) && !out_in.dz) begin
         out_in.re     = q_re.val;
         out_in.im     = q_im.val;
         out_in.status = (q_re.ovf || q_im.ovf) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_re_ff     <= out_in.re;
      rsp_im_ff     <= out_in.im;
      rsp_flag_ff   <= out_in.flag;
      rsp_status_ff <= out_in.status;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_res_re = rsp_re_ff;
   assign rsp_res_im = rsp_im_ff;
   assign rsp_flag   = rsp_flag_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(NST + 1) rsp_valid)
      else $error("transaction result missing at fixed latency");

   a_flag_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flag) |-> (rsp_status == ST_OK && rsp_res_re == 32'sd0
                                   && rsp_res_im == 32'sd0))
      else $error("compare result carries data or status");

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DIVZ) |-> (rsp_res_re == 32'sd0
                                               && rsp_res_im == 32'sd0 && !rsp_flag))
      else $error("division by zero result not cleared");

   a_sat_noflag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_SAT) |-> !rsp_flag)
      else $error("saturated result with compare flag");
`endif
endmodule
